@@ hdl/complex_divide_and_integer_power_top_assert.svh @@
// Assertion macros for the complex divide and power block
`ifndef COMPLEX_DIVIDE_AND_INTEGER_POWER_TOP_ASSERT_SVH
`define COMPLEX_DIVIDE_AND_INTEGER_POWER_TOP_ASSERT_SVH
// same-cycle implication, checked out of reset
`define CDIP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cdip assertion failed");
// next-cycle implication, checked out of reset
`define CDIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cdip assertion failed");
`endif

@@ hdl/cdip_pkg.sv @@
// Package: types and constants of the complex divide and power block
`timescale 1ns / 1ps
package cdip_pkg;
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int EXP_BITS  = 32;
    localparam int MUL_W     = WORD_BITS + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int DEN_W     = 2 * WORD_BITS;
    localparam int REM_W     = DEN_W + 1;
    localparam int MAG_W     = DEN_W + 1;
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    localparam int CNT_W     = $clog2(DVD_W);
    localparam int BITS_W    = $clog2(EXP_BITS);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_ZNEG = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    typedef struct packed {
        logic                        op;
        logic signed [WORD_BITS-1:0] a_re;
        logic signed [WORD_BITS-1:0] a_im;
        logic signed [WORD_BITS-1:0] b_re;
        logic signed [WORD_BITS-1:0] b_im;
        logic signed [EXP_BITS-1:0]  exponent;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] res_re;
        logic signed [WORD_BITS-1:0] res_im;
        t_status                     status;
    } t_out_item;
endpackage

@@ hdl/complex_divide_and_integer_power_top.sv @@
// Top level: complex divide and signed integer power, one shared multiplier and divider
// Divide: two complex products (denominator b*conj(b), numerator a*conj(b)), then two 81-step
// divisions. Power: exponent alignment, then a squaring per remaining exponent bit and a multiply
// for each set bit; a negative exponent first forms the reciprocal 1/a through the divide path.
// One item at a time: busy is high from acceptance until the result strobe.
// Synchronous active-low reset returns the sequencer to idle; results cannot be stalled.
`timescale 1ns / 1ps
module complex_divide_and_integer_power_top
    import cdip_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_res
);
    `include "complex_divide_and_integer_power_top_assert.svh"

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_NORM = 7'b0000010,
        S_LOOP = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    typedef enum logic [5:0] {
        PH_DEN   = 6'b000001,
        PH_NUM   = 6'b000010,
        PH_DIVRE = 6'b000100,
        PH_DIVIM = 6'b001000,
        PH_SQ    = 6'b010000,
        PH_MX    = 6'b100000
    } t_phase;

    localparam logic signed [WORD_BITS-1:0] ONE  = WORD_BITS'(1) <<< FRAC_BITS;
    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    t_state  r_state;
    t_phase  r_ph;
    t_status r_status;
    logic    r_op, r_sat;
    logic [2:0] r_k;
    logic signed [WORD_BITS-1:0] r_ar, r_ai, r_br, r_bi, r_xr, r_xi, r_rr, r_ri;
    logic signed [MUL_W-1:0] r_pr, r_pi, r_qr, r_qi;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc_re, r_acc_im, r_ni;
    logic [DEN_W-1:0] r_den;
    logic [EXP_BITS-1:0] r_mag;
    logic [BITS_W-1:0] r_bits;
    logic [REM_W-1:0] r_rem;
    logic [DVD_W-1:0] r_dvd, r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic r_qneg;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0] prod_ext;
    logic [REM_W-1:0] rem2;
    logic rem_ge;
    logic [WORD_BITS:0] sat_re, sat_im, div_q;
    logic [EXP_BITS-1:0] exp_mag;

    function automatic logic [WORD_BITS:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        logic fits;
        s = v >>> FRAC_BITS;
        fits = (&s[ACC_W-1:WORD_BITS-1]) || !(|s[ACC_W-1:WORD_BITS-1]);
        if (fits) return {1'b0, s[WORD_BITS-1:0]};
        return {1'b1, s[ACC_W-1] ? WMIN : WMAX};
    endfunction

    function automatic logic [DVD_W-1:0] dvd_of(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] m;
        m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        return {m[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    endfunction

    function automatic logic [WORD_BITS:0] q_word(input logic [DVD_W-1:0] q, input logic neg);
        logic over;
        if (neg) begin
            over = (|q[DVD_W-1:WORD_BITS]) || (q[WORD_BITS-1] && (|q[WORD_BITS-2:0]));
            return over ? {1'b1, WMIN} : {1'b0, WORD_BITS'(-q[WORD_BITS-1:0])};
        end
        over = |q[DVD_W-1:WORD_BITS-1];
        return over ? {1'b1, WMAX} : {1'b0, q[WORD_BITS-1:0]};
    endfunction

    always_comb begin
        case (r_k[1:0])
            2'd0:    begin mul_a = r_pr; mul_b = r_qr; end
            2'd1:    begin mul_a = r_pi; mul_b = r_qi; end
            2'd2:    begin mul_a = r_pr; mul_b = r_qi; end
            default: begin mul_a = r_pi; mul_b = r_qr; end
        endcase
    end

    assign n_prod   = mul_a * mul_b;
    assign prod_ext = ACC_W'(r_prod);
    assign rem2     = {r_rem[REM_W-2:0], r_dvd[DVD_W-1]};
    assign rem_ge   = rem2 >= {1'b0, r_den};
    assign sat_re   = sat_word(r_acc_re);
    assign sat_im   = sat_word(r_acc_im);
    assign div_q    = q_word(r_quo, r_qneg);
    assign exp_mag  = i_item.exponent[EXP_BITS-1] ? EXP_BITS'(-i_item.exponent)
                                                  : EXP_BITS'(i_item.exponent);
    assign busy     = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op     <= i_item.op;
                        r_status <= ST_OK;
                        r_sat    <= 1'b0;
                        r_rr     <= '0;
                        r_ri     <= '0;
                        r_ar     <= i_item.a_re;
                        r_ai     <= i_item.a_im;
                        r_br     <= i_item.b_re;
                        r_bi     <= i_item.b_im;
                        r_mag    <= exp_mag;
                        r_bits   <= BITS_W'(EXP_BITS - 1);
                        r_k      <= '0;
                        r_acc_re <= '0;
                        r_acc_im <= '0;
                        r_ph     <= PH_DEN;
                        if (!i_item.op) begin
                            r_pr <= MUL_W'(i_item.b_re);
                            r_pi <= MUL_W'(i_item.b_im);
                            r_qr <= MUL_W'(i_item.b_re);
                            r_qi <= -MUL_W'(i_item.b_im);
                            if (i_item.b_re == '0 && i_item.b_im == '0) begin
                                r_status <= ST_DIV0;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_MUL;
                            end
                        end else begin
                            r_pr <= MUL_W'(i_item.a_re);
                            r_pi <= MUL_W'(i_item.a_im);
                            r_qr <= MUL_W'(i_item.a_re);
                            r_qi <= -MUL_W'(i_item.a_im);
                            if (i_item.exponent[EXP_BITS-1] && i_item.a_re == '0
                                    && i_item.a_im == '0) begin
                                r_status <= ST_ZNEG;
                                r_state  <= S_DONE;
                            end else if (exp_mag == '0) begin
                                r_rr    <= ONE;
                                r_state <= S_DONE;
                            end else if (i_item.exponent[EXP_BITS-1]) begin
                                r_ar    <= ONE;
                                r_ai    <= '0;
                                r_br    <= i_item.a_re;
                                r_bi    <= i_item.a_im;
                                r_state <= S_MUL;
                            end else begin
                                r_xr    <= i_item.a_re;
                                r_xi    <= i_item.a_im;
                                r_rr    <= i_item.a_re;
                                r_ri    <= i_item.a_im;
                                r_state <= S_NORM;
                            end
                        end
                    end
                end
                S_MUL: begin
                    if (r_k != 3'd4) r_prod <= n_prod;
                    case (r_k)
                        3'd1:    r_acc_re <= r_acc_re + prod_ext;
                        3'd2:    r_acc_re <= r_acc_re - prod_ext;
                        3'd3,
                        3'd4:    r_acc_im <= r_acc_im + prod_ext;
                        default: ;
                    endcase
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd4) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_k      <= '0;
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                    r_rem    <= '0;
                    r_quo    <= '0;
                    r_cnt    <= CNT_W'(DVD_W - 1);
                    unique case (r_ph)
                        PH_DEN: begin
                            r_den   <= r_acc_re[DEN_W-1:0];
                            r_pr    <= MUL_W'(r_ar);
                            r_pi    <= MUL_W'(r_ai);
                            r_qr    <= MUL_W'(r_br);
                            r_qi    <= -MUL_W'(r_bi);
                            r_ph    <= PH_NUM;
                            r_state <= S_MUL;
                        end
                        PH_NUM: begin
                            r_ni    <= r_acc_im;
                            r_dvd   <= dvd_of(r_acc_re);
                            r_qneg  <= r_acc_re[ACC_W-1];
                            r_ph    <= PH_DIVRE;
                            r_state <= S_DIV;
                        end
                        PH_DIVRE: begin
                            r_rr    <= div_q[WORD_BITS-1:0];
                            r_sat   <= r_sat | div_q[WORD_BITS];
                            r_dvd   <= dvd_of(r_ni);
                            r_qneg  <= r_ni[ACC_W-1];
                            r_ph    <= PH_DIVIM;
                            r_state <= S_DIV;
                        end
                        PH_DIVIM: begin
                            r_ri  <= div_q[WORD_BITS-1:0];
                            r_xr  <= r_rr;
                            r_xi  <= div_q[WORD_BITS-1:0];
                            r_sat <= r_sat | div_q[WORD_BITS];
                            r_state <= r_op ? S_NORM : S_DONE;
                        end
                        PH_SQ: begin
                            r_rr  <= sat_re[WORD_BITS-1:0];
                            r_ri  <= sat_im[WORD_BITS-1:0];
                            r_sat <= r_sat | sat_re[WORD_BITS] | sat_im[WORD_BITS];
                            r_pr  <= MUL_W'($signed(sat_re[WORD_BITS-1:0]));
                            r_pi  <= MUL_W'($signed(sat_im[WORD_BITS-1:0]));
                            r_qr  <= MUL_W'(r_xr);
                            r_qi  <= MUL_W'(r_xi);
                            r_ph  <= PH_MX;
                            r_state <= r_mag[EXP_BITS-1] ? S_MUL : S_LOOP;
                        end
                        PH_MX: begin
                            r_rr    <= sat_re[WORD_BITS-1:0];
                            r_ri    <= sat_im[WORD_BITS-1:0];
                            r_sat   <= r_sat | sat_re[WORD_BITS] | sat_im[WORD_BITS];
                            r_state <= S_LOOP;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_DIV: begin
                    r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                    r_rem <= rem_ge ? rem2 - {1'b0, r_den} : rem2;
                    r_quo <= {r_quo[DVD_W-2:0], rem_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) r_state <= S_FIN;
                end
                S_NORM: begin
                    if (r_mag[EXP_BITS-1]) begin
                        r_state <= S_LOOP;
                    end else begin
                        r_mag  <= {r_mag[EXP_BITS-2:0], 1'b0};
                        r_bits <= r_bits - BITS_W'(1);
                    end
                end
                S_LOOP: begin
                    if (r_bits == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_mag    <= {r_mag[EXP_BITS-2:0], 1'b0};
                        r_bits   <= r_bits - BITS_W'(1);
                        r_pr     <= MUL_W'(r_rr);
                        r_pi     <= MUL_W'(r_ri);
                        r_qr     <= MUL_W'(r_rr);
                        r_qi     <= MUL_W'(r_ri);
                        r_k      <= '0;
                        r_acc_re <= '0;
                        r_acc_im <= '0;
                        r_ph     <= PH_SQ;
                        r_state  <= S_MUL;
                    end
                end
                S_DONE: begin
                    o_done        <= 1'b1;
                    o_res.res_re  <= r_rr;
                    o_res.res_im  <= r_ri;
                    o_res.status  <= (r_status == ST_OK && r_sat) ? ST_SAT : r_status;
                    r_state       <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CDIP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `CDIP_ASSERT_NEXT(a_done_single, o_done, !o_done)
    `CDIP_ASSERT_NOW(a_done_idle, o_done, !busy)
    `CDIP_ASSERT_NOW(a_err_zero, o_done && (o_res.status == ST_DIV0 || o_res.status == ST_ZNEG), o_res.res_re == '0 && o_res.res_im == '0)
endmodule
